FILE: design/adts_frame_deframer_defines.svh
// Assertion macros shared by the ADTS deframer.
`ifndef ADTS_FRAME_DEFRAMER_DEFINES_SVH
`define ADTS_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adts assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adts assertion failed");

`endif

FILE: design/adts_pkg.sv
// Types and constants of the ADTS frame deframer.
package adts_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_CRC     = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   localparam logic [7:0] SYNC_FIRST   = 8'hFF;
   localparam logic [3:0] SYNC_NIBBLE  = 4'hF;

   localparam logic [12:0] HDR_LEN_PLAIN = 13'd7;
   localparam logic [12:0] HDR_LEN_CRC   = 13'd9;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [1:0]  byte_kind;
      logic        frame_end;
      logic        header_done;
      logic        frame_error;
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [2:0]  channel_config;
      logic [12:0] frame_length;
      logic [10:0] buffer_fullness;
      logic [1:0]  raw_blocks;
      logic [8:0]  header_flags;
   } rsp_type;

endpackage

FILE: design/adts_req_if.sv
// Request channel of the ADTS deframer: one stream byte per request.
interface adts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: design/adts_rsp_if.sv
// Result channel of the ADTS deframer: one result per stream byte.
interface adts_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [1:0]  byte_kind;
   logic        frame_end;
   logic        header_done;
   logic        frame_error;
   logic [1:0]  profile;
   logic [3:0]  rate_index;
   logic [2:0]  channel_config;
   logic [12:0] frame_length;
   logic [10:0] buffer_fullness;
   logic [1:0]  raw_blocks;
   logic [8:0]  header_flags;

   modport source (output valid, output data_byte, output byte_kind, output frame_end,
                   output header_done, output frame_error, output profile,
                   output rate_index, output channel_config, output frame_length,
                   output buffer_fullness, output raw_blocks, output header_flags,
                   input ready);
   modport sink (input valid, input data_byte, input byte_kind, input frame_end,
                 input header_done, input frame_error, input profile,
                 input rate_index, input channel_config, input frame_length,
                 input buffer_fullness, input raw_blocks, input header_flags,
                 output ready);
endinterface

FILE: design/adts_frame_deframer.sv
// Top level of the ADTS frame deframer: byte classification and header decode.
//
// The deframer takes one byte of an AAC ADTS stream per request and returns one
// result per byte in the cycle after the byte is accepted. It hunts for the sync word,
// unpacks the header fields on the seventh header byte, tags the two CRC bytes when
// protection is present and then passes the payload, marking the last byte of each
// frame. A bad sync word or a frame length shorter than the header raises frame_error
// and restarts the hunt at the next byte. Throughput is one byte per clock: the frame
// state and the result register are updated in the same cycle, and req ready drops
// only while the result register holds a result that has not been taken.
module adts_frame_deframer
   import adts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   adts_req_if.sink   req_chan,
   adts_rsp_if.source rsp_chan
);

`include "adts_frame_deframer_defines.svh"

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_CRC     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_UNUSED  = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [12:0] count_ff, count_in;
   logic [12:0] length_ff, length_in;
   logic        crc_ff, crc_in;
   logic [7:0]  hdr_ff [1:5];
   logic        hdr_we;
   logic [2:0]  hdr_idx;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic [1:0]  cur_phase;
   logic [12:0] cur_count;
   logic [7:0]  b;
   logic [12:0] flen;
   logic [12:0] hdr_len;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.stream_byte;

   // An unused phase code falls back to header collection from byte zero.
   assign cur_phase = (phase_ff == PH_UNUSED) ? PH_HEADER : phase_ff;
   assign cur_count = (phase_ff == PH_UNUSED) ? '0 : count_ff;

   assign flen    = {hdr_ff[3][1:0], hdr_ff[4], hdr_ff[5][7:5]};
   assign hdr_len = crc_ff ? HDR_LEN_CRC : HDR_LEN_PLAIN;
   assign hdr_idx = cur_count[2:0];

   always_comb begin
      rsp_in           = '0;
      rsp_in.data_byte = b;
      phase_in         = cur_phase;
      count_in         = cur_count;
      length_in        = length_ff;
      crc_in           = crc_ff;
      hdr_we           = 1'b0;
      unique case (cur_phase)
         PH_HEADER: begin
            rsp_in.byte_kind = KIND_HEADER;
            if (cur_count == 13'd0 && b != SYNC_FIRST) begin
               rsp_in.frame_error = 1'b1;
               count_in           = '0;
            end else if (cur_count == 13'd1 && b[7:4] != SYNC_NIBBLE) begin
               rsp_in.frame_error = 1'b1;
               count_in           = '0;
            end else if (cur_count < 13'd6) begin
               if (cur_count == 13'd1) begin
                  crc_in = ~b[0];
               end
               hdr_we   = (cur_count != 13'd0);
               count_in = cur_count + 13'd1;
            end else begin
               rsp_in.header_done     = 1'b1;
               rsp_in.profile         = hdr_ff[2][7:6];
               rsp_in.rate_index      = hdr_ff[2][5:2];
               rsp_in.channel_config  = {hdr_ff[2][0], hdr_ff[3][7:6]};
               rsp_in.frame_length    = flen;
               rsp_in.buffer_fullness = {hdr_ff[5][4:0], b[7:2]};
               rsp_in.raw_blocks      = b[1:0];
               rsp_in.header_flags    = {hdr_ff[1][3], hdr_ff[1][2:1], hdr_ff[1][0],
                                         hdr_ff[2][1], hdr_ff[3][5], hdr_ff[3][4],
                                         hdr_ff[3][3], hdr_ff[3][2]};
               priority if (flen < hdr_len) begin
                  rsp_in.frame_error = 1'b1;
                  count_in           = '0;
               end else if (crc_ff) begin
                  length_in = flen;
                  phase_in  = PH_CRC;
                  count_in  = 13'd7;
               end else if (flen == HDR_LEN_PLAIN) begin
                  length_in        = flen;
                  rsp_in.frame_end = 1'b1;
                  count_in         = '0;
               end else begin
                  length_in = flen;
                  phase_in  = PH_PAYLOAD;
                  count_in  = 13'd7;
               end
            end
         end
         PH_CRC: begin
            rsp_in.byte_kind = KIND_CRC;
            priority if (cur_count < 13'd8) begin
               count_in = 13'd8;
            end else if (length_ff == HDR_LEN_CRC) begin
               rsp_in.frame_end = 1'b1;
               phase_in         = PH_HEADER;
               count_in         = '0;
            end else begin
               phase_in = PH_PAYLOAD;
               count_in = 13'd9;
            end
         end
         PH_PAYLOAD: begin
            rsp_in.byte_kind = KIND_PAYLOAD;
            if ({1'b0, cur_count} + 14'd1 >= {1'b0, length_ff}) begin
               rsp_in.frame_end = 1'b1;
               phase_in         = PH_HEADER;
               count_in         = '0;
            end else begin
               count_in = cur_count + 13'd1;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         length_ff    <= '0;
         crc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            crc_ff    <= crc_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hdr_we) begin
         hdr_ff[hdr_idx] <= b;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.data_byte       = rsp_ff.data_byte;
   assign rsp_chan.byte_kind       = rsp_ff.byte_kind;
   assign rsp_chan.frame_end       = rsp_ff.frame_end;
   assign rsp_chan.header_done     = rsp_ff.header_done;
   assign rsp_chan.frame_error     = rsp_ff.frame_error;
   assign rsp_chan.profile         = rsp_ff.profile;
   assign rsp_chan.rate_index      = rsp_ff.rate_index;
   assign rsp_chan.channel_config  = rsp_ff.channel_config;
   assign rsp_chan.frame_length    = rsp_ff.frame_length;
   assign rsp_chan.buffer_fullness = rsp_ff.buffer_fullness;
   assign rsp_chan.raw_blocks      = rsp_ff.raw_blocks;
   assign rsp_chan.header_flags    = rsp_ff.header_flags;

   // The payload counter never reaches the frame length while payload is flowing.
   `ADTS_ASSERT_SAME(a_payload_in_frame, clock, reset, phase_ff == PH_PAYLOAD,
                     count_ff < length_ff)
   // CRC bytes are only tagged for frames that carry a CRC.
   `ADTS_ASSERT_SAME(a_crc_needs_flag, clock, reset, phase_ff == PH_CRC, crc_ff)
   // A first byte that is not the sync byte is reported as an error.
   `ADTS_ASSERT_NEXT(a_sync_error, clock, reset,
                     accept && phase_ff == PH_HEADER && count_ff == 13'd0 &&
                     req_chan.stream_byte != SYNC_FIRST,
                     rsp_chan.valid && rsp_chan.frame_error)
   // Decoded header fields only ever come with a header byte.
   `ADTS_ASSERT_SAME(a_done_is_header, clock, reset,
                     rsp_chan.valid && rsp_chan.header_done,
                     rsp_chan.byte_kind == KIND_HEADER)

endmodule

FILE: test/adts_frame_deframer_tb.sv
// Self-checking testbench of the ADTS frame deframer: framed, broken and noisy byte streams.
module adts_frame_deframer_tb;
   import adts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_CRC     = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } hunt_phase_type;

   // Header fields in the layout of the result; flags[5] is set when no CRC follows.
   typedef struct {
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [2:0]  channel_config;
      logic [12:0] frame_length;
      logic [10:0] buffer_fullness;
      logic [1:0]  raw_blocks;
      logic [8:0]  header_flags;
   } header_fields_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   adts_req_if req_if ();
   adts_rsp_if rsp_if ();

   adts_frame_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [7:0]  stream_bytes[$];
   rsp_type     expected_rsp[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   logic        req_taken = 1'b0;

   // Deframer state as the testbench sees it.
   hunt_phase_type hunt_phase = PHASE_HEADER;
   logic [12:0]    frame_pos = '0;
   logic [7:0]     header_bytes[6];
   logic [12:0]    held_length = '0;
   logic           crc_on = 1'b0;

   function automatic void resync();
      hunt_phase = PHASE_HEADER;
      frame_pos = '0;
   endfunction

   function automatic rsp_type deframe_byte(logic [7:0] b);
      rsp_type     r;
      logic [12:0] hdr_len;
      r = '0;
      r.data_byte = b;
      case (hunt_phase)
         PHASE_CRC: begin
            r.byte_kind = KIND_CRC;
            if (frame_pos < 13'd8) begin
               frame_pos = 13'd8;
            end else if (held_length == HDR_LEN_CRC) begin
               r.frame_end = 1'b1;
               resync();
            end else begin
               hunt_phase = PHASE_PAYLOAD;
               frame_pos = 13'd9;
            end
         end
         PHASE_PAYLOAD: begin
            r.byte_kind = KIND_PAYLOAD;
            if ({1'b0, frame_pos} + 14'd1 >= {1'b0, held_length}) begin
               r.frame_end = 1'b1;
               resync();
            end else begin
               frame_pos = frame_pos + 13'd1;
            end
         end
         default: begin
            r.byte_kind = KIND_HEADER;
            if (frame_pos == 13'd0 && b != SYNC_FIRST) begin
               r.frame_error = 1'b1;
               resync();
               return r;
            end
            if (frame_pos == 13'd1) begin
               if (b[7:4] != SYNC_NIBBLE) begin
                  r.frame_error = 1'b1;
                  resync();
                  return r;
               end
               crc_on = !b[0];
            end
            if (frame_pos < 13'd6) begin
               header_bytes[frame_pos] = b;
               frame_pos = frame_pos + 13'd1;
               return r;
            end
            r.header_done     = 1'b1;
            r.profile         = header_bytes[2][7:6];
            r.rate_index      = header_bytes[2][5:2];
            r.channel_config  = {header_bytes[2][0], header_bytes[3][7:6]};
            r.frame_length    = {header_bytes[3][1:0], header_bytes[4], header_bytes[5][7:5]};
            r.buffer_fullness = {header_bytes[5][4:0], b[7:2]};
            r.raw_blocks      = b[1:0];
            r.header_flags    = {header_bytes[1][3], header_bytes[1][2:1], header_bytes[1][0],
                                 header_bytes[2][1], header_bytes[3][5:2]};
            hdr_len = crc_on ? HDR_LEN_CRC : HDR_LEN_PLAIN;
            if (r.frame_length < hdr_len) begin
               r.frame_error = 1'b1;
               resync();
               return r;
            end
            held_length = r.frame_length;
            if (crc_on) begin
               hunt_phase = PHASE_CRC;
               frame_pos = 13'd7;
            end else if (held_length == HDR_LEN_PLAIN) begin
               r.frame_end = 1'b1;
               resync();
            end else begin
               hunt_phase = PHASE_PAYLOAD;
               frame_pos = 13'd7;
            end
         end
      endcase
      return r;
   endfunction

   function automatic header_fields_type random_header(bit with_crc, int unsigned len);
      header_fields_type h;
      h.profile         = 2'($urandom);
      h.rate_index      = 4'($urandom);
      h.channel_config  = 3'($urandom);
      h.frame_length    = 13'(len);
      h.buffer_fullness = 11'($urandom);
      h.raw_blocks      = 2'($urandom);
      h.header_flags    = 9'($urandom);
      h.header_flags[5] = !with_crc;
      return h;
   endfunction

   // Queues a whole frame, or only its first keep bytes when keep is positive.
   task automatic queue_frame(input header_fields_type h, input int keep);
      logic [7:0] frame_bytes[$];
      int         hdr_len;
      frame_bytes.push_back(SYNC_FIRST);
      frame_bytes.push_back({SYNC_NIBBLE, h.header_flags[8], h.header_flags[7:6],
                             h.header_flags[5]});
      frame_bytes.push_back({h.profile, h.rate_index, h.header_flags[4],
                             h.channel_config[2]});
      frame_bytes.push_back({h.channel_config[1:0], h.header_flags[3:0],
                             h.frame_length[12:11]});
      frame_bytes.push_back(h.frame_length[10:3]);
      frame_bytes.push_back({h.frame_length[2:0], h.buffer_fullness[10:6]});
      frame_bytes.push_back({h.buffer_fullness[5:0], h.raw_blocks});
      hdr_len = h.header_flags[5] ? int'(HDR_LEN_PLAIN) : int'(HDR_LEN_CRC);
      // A short frame stops after the seventh byte, so nothing more is sent for it.
      if (h.frame_length >= hdr_len) begin
         repeat (int'(h.frame_length) - 7) frame_bytes.push_back(8'($urandom));
      end
      if (keep <= 0 || keep > frame_bytes.size()) begin
         keep = frame_bytes.size();
      end
      for (int i = 0; i < keep; i++) begin
         stream_bytes.push_back(frame_bytes[i]);
      end
   endtask

   function automatic bit take_break();
      // A long calm stretch without breaks recurs periodically.
      if ((cycle_count % 6000) >= 3500 && (cycle_count % 6000) < 5000) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 27;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_taken) begin
            if (stream_bytes.size() != 0 && !take_break()) begin
               req_if.valid <= 1'b1;
               req_if.stream_byte <= stream_bytes.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= !take_break();
      end
   end

   task automatic check_field(input string name, input logic [12:0] want,
                              input logic [12:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result with data_byte %0d arrived with none expected",
                      rsp_if.data_byte);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("data_byte", want.data_byte, rsp_if.data_byte);
               check_field("byte_kind", want.byte_kind, rsp_if.byte_kind);
               check_field("frame_end", want.frame_end, rsp_if.frame_end);
               check_field("header_done", want.header_done, rsp_if.header_done);
               check_field("frame_error", want.frame_error, rsp_if.frame_error);
               check_field("profile", want.profile, rsp_if.profile);
               check_field("rate_index", want.rate_index, rsp_if.rate_index);
               check_field("channel_config", want.channel_config, rsp_if.channel_config);
               check_field("frame_length", want.frame_length, rsp_if.frame_length);
               check_field("buffer_fullness", want.buffer_fullness, rsp_if.buffer_fullness);
               check_field("raw_blocks", want.raw_blocks, rsp_if.raw_blocks);
               check_field("header_flags", want.header_flags, rsp_if.header_flags);
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_rsp.push_back(deframe_byte(req_if.stream_byte));
         end
      end
   end

   initial begin : stimulus
      header_fields_type h;
      int unsigned       random_count;
      int unsigned       start_size;
      int unsigned       pick;
      int unsigned       len;
      bit                with_crc;

      req_if.valid = 1'b0;
      req_if.stream_byte = '0;
      rsp_if.ready = 1'b0;

      // Directed: bad first sync byte, bad sync nibble, then a short frame with every field
      // but the protection flag at zero, a protected frame with all fields but the length and
      // that flag at their maximum and one payload byte, and a frame that is nothing but its header.
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(SYNC_FIRST);
      stream_bytes.push_back(8'hE1);
      h = random_header(1'b0, 0);
      h.profile = '0; h.rate_index = '0; h.channel_config = '0;
      h.buffer_fullness = '0; h.raw_blocks = '0; h.header_flags = 9'h020;
      queue_frame(h, 0);
      h.profile = '1; h.rate_index = '1; h.channel_config = '1; h.frame_length = 13'd10;
      h.buffer_fullness = '1; h.raw_blocks = '1; h.header_flags = 9'h1DF;
      queue_frame(h, 0);
      queue_frame(random_header(1'b0, 32'(HDR_LEN_PLAIN)), 0);

      random_count = 0;
      while (random_count < 1500) begin
         start_size = stream_bytes.size();
         pick = $urandom_range(0, 99);
         with_crc = 1'($urandom_range(0, 1));
         len = with_crc ? 32'(HDR_LEN_CRC) : 32'(HDR_LEN_PLAIN);
         if (pick < 86) begin
            case ($urandom_range(0, 24))
               0, 1:    len = $urandom_range(0, len);
               2:       len = $urandom_range(len, 400);
               default: len = len + $urandom_range(0, 24);
            endcase
            queue_frame(random_header(with_crc, len), 0);
         end else if (pick < 92) begin
            // Frame cut short after at least its first seven bytes.
            len = len + $urandom_range(1, 20);
            queue_frame(random_header(with_crc, len), $urandom_range(7, len - 1));
         end else if (pick < 96) begin
            stream_bytes.push_back(SYNC_FIRST);
            stream_bytes.push_back({4'($urandom_range(0, 14)), 4'($urandom)});
         end else begin
            repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom));
         end
         random_count += stream_bytes.size() - start_size;
      end
      // A header of the greatest length ends the stream, with its payload cut short.
      queue_frame(random_header(1'b1, 8191), 24);

      while (stream_bytes.size() != 0 || req_if.valid !== 1'b0 || reset) begin
         @(posedge clock);
      end
      while (expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : reset_drive
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
